/* hw/rtl/iatmr_pkg.sv */
// ----------------------------------------------------------------------------
// iatmr_pkg
// Types, constants and saturating time helpers shared by the interval and
// alarm timer.
// ----------------------------------------------------------------------------
package iatmr_pkg;

  localparam int TIME_BITS     = 48;
  localparam int COUNT_BITS    = 32;
  localparam int TOD_BITS      = 27;
  localparam int SPAN_BITS     = 30;
  localparam int HOUR_BITS     = 8;
  localparam int MIN_BITS      = 8;
  localparam int SEC_BITS      = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [SPAN_BITS-1:0] MS_PER_HOUR   = SPAN_BITS'(3600000);
  localparam logic [SPAN_BITS-1:0] MS_PER_MINUTE = SPAN_BITS'(60000);
  localparam logic [SPAN_BITS-1:0] MS_PER_DAY    = SPAN_BITS'(86400000);

  localparam logic [HOUR_BITS-1:0] HOURS_PER_DAY  = HOUR_BITS'(24);
  localparam logic [MIN_BITS-1:0]  MINS_PER_HOUR  = MIN_BITS'(60);
  localparam logic [SEC_BITS-1:0]  MS_PER_MIN_SEC = SEC_BITS'(60000);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLE        = 3'd0,
    REG_ALARM_MODE    = 3'd1,
    REG_HOURS         = 3'd2,
    REG_MINUTES       = 3'd3,
    REG_SECOND_MILLIS = 3'd4,
    REG_OFFSET_MILLIS = 3'd5,
    REG_RUN_DISC      = 3'd6,
    REG_SINGLE_SHOT   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] now_ms;
    logic [TOD_BITS-1:0]  ms_of_day;
    logic                 link_up;
  } in_item_t;

  typedef struct packed {
    logic                  fired;
    logic [TIME_BITS-1:0]  next_fire_ms;
    logic                  next_fire_ok;
    logic [COUNT_BITS-1:0] fires_so_far;
    logic [TIME_BITS-1:0]  last_fire_ms;
  } out_item_t;

  // settings as seen by the datapath
  typedef struct packed {
    logic                 enable;
    logic                 alarm_mode;
    logic                 run_disconnected;
    logic                 single_shot;
    logic [SPAN_BITS-1:0] span;
    logic [SPAN_BITS-1:0] offset;
    logic                 at_ok;
    logic [SPAN_BITS-1:0] step;
  } cfg_t;

  // setup candidate for one item
  typedef struct packed {
    logic [TIME_BITS-1:0] now_ms;
    logic                 link_up;
    logic [TIME_BITS-1:0] sched;
    logic                 sched_ok;
    logic                 sched_le;
    logic [TIME_BITS-1:0] sched_adv;
    logic                 sched_adv_le;
  } cand_t;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] sat_sub(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    return (b > a) ? {TIME_BITS{1'b0}} : a - b;
  endfunction

endpackage

/* hw/rtl/iatmr_cfg.sv */
// ----------------------------------------------------------------------------
// iatmr_cfg
// Settings registers, with the span in milliseconds, the alarm range check
// and the reschedule step kept ready alongside them.
// ----------------------------------------------------------------------------
module iatmr_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [iatmr_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [iatmr_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                 shot_clear_i,
  output iatmr_pkg::cfg_t                      cfg_o
);

  logic                                enable_q, enable_d;
  logic                                alarm_q, alarm_d;
  logic [iatmr_pkg::HOUR_BITS-1:0]     hours_q, hours_d;
  logic [iatmr_pkg::MIN_BITS-1:0]      minutes_q, minutes_d;
  logic [iatmr_pkg::SEC_BITS-1:0]      smillis_q, smillis_d;
  logic [iatmr_pkg::SPAN_BITS-1:0]     offset_q, offset_d;
  logic                                rundisc_q, rundisc_d;
  logic                                single_q, single_d;
  logic [iatmr_pkg::SPAN_BITS-1:0]     span_q, span_d;
  logic                                at_ok_q, at_ok_d;
  logic [iatmr_pkg::SPAN_BITS-1:0]     step_q, step_d;
  logic                                wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_comb begin
    enable_d  = enable_q;
    alarm_d   = alarm_q;
    hours_d   = hours_q;
    minutes_d = minutes_q;
    smillis_d = smillis_q;
    offset_d  = offset_q;
    rundisc_d = rundisc_q;
    single_d  = single_q;
    if (shot_clear_i) begin
      enable_d = 1'b0;
    end
    if (wr) begin
      case (iatmr_pkg::cfg_reg_e'(cfg_index_i))
        iatmr_pkg::REG_ENABLE:        enable_d  = cfg_data_i[0];
        iatmr_pkg::REG_ALARM_MODE:    alarm_d   = cfg_data_i[0];
        iatmr_pkg::REG_HOURS:         hours_d   = cfg_data_i[iatmr_pkg::HOUR_BITS-1:0];
        iatmr_pkg::REG_MINUTES:       minutes_d = cfg_data_i[iatmr_pkg::MIN_BITS-1:0];
        iatmr_pkg::REG_SECOND_MILLIS: smillis_d = cfg_data_i[iatmr_pkg::SEC_BITS-1:0];
        iatmr_pkg::REG_OFFSET_MILLIS: offset_d  = cfg_data_i[iatmr_pkg::SPAN_BITS-1:0];
        iatmr_pkg::REG_RUN_DISC:      rundisc_d = cfg_data_i[0];
        iatmr_pkg::REG_SINGLE_SHOT:   single_d  = cfg_data_i[0];
        default: ;
      endcase
    end
    span_d  = iatmr_pkg::SPAN_BITS'(hours_d) * iatmr_pkg::MS_PER_HOUR
            + iatmr_pkg::SPAN_BITS'(minutes_d) * iatmr_pkg::MS_PER_MINUTE
            + iatmr_pkg::SPAN_BITS'(smillis_d);
    at_ok_d = (hours_d < iatmr_pkg::HOURS_PER_DAY) && (minutes_d < iatmr_pkg::MINS_PER_HOUR)
              && (smillis_d < iatmr_pkg::MS_PER_MIN_SEC);
    step_d  = alarm_d ? iatmr_pkg::MS_PER_DAY : span_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      alarm_q   <= 1'b0;
      hours_q   <= '0;
      minutes_q <= '0;
      smillis_q <= '0;
      offset_q  <= '0;
      rundisc_q <= 1'b0;
      single_q  <= 1'b0;
      span_q    <= '0;
      at_ok_q   <= 1'b1;
      step_q    <= '0;
    end else begin
      enable_q  <= enable_d;
      alarm_q   <= alarm_d;
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
      smillis_q <= smillis_d;
      offset_q  <= offset_d;
      rundisc_q <= rundisc_d;
      single_q  <= single_d;
      span_q    <= span_d;
      at_ok_q   <= at_ok_d;
      step_q    <= step_d;
    end
  end

  assign cfg_o.enable           = enable_q;
  assign cfg_o.alarm_mode       = alarm_q;
  assign cfg_o.run_disconnected = rundisc_q;
  assign cfg_o.single_shot      = single_q;
  assign cfg_o.span             = span_q;
  assign cfg_o.offset           = offset_q;
  assign cfg_o.at_ok            = at_ok_q;
  assign cfg_o.step             = step_q;

  a_shot_clears_enable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shot_clear_i && !wr) |=> !enable_q)
    else $error("one-shot fire did not clear enable");

  a_step_tracks_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_q |-> step_q == iatmr_pkg::MS_PER_DAY)
    else $error("alarm step is not one day");

  a_span_zero_after_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hours_q == '0 && minutes_q == '0) |-> span_q == iatmr_pkg::SPAN_BITS'(smillis_q))
    else $error("span out of step with its fields");

endmodule

/* hw/rtl/iatmr_sched.sv */
// ----------------------------------------------------------------------------
// iatmr_sched
// Input register and three short stages that work out the fresh schedule
// for an item, whether it is due, and where it moves after a fire.
// ----------------------------------------------------------------------------
module iatmr_sched (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  iatmr_pkg::in_item_t in_data_i,
  input  logic                adv_i,
  input  iatmr_pkg::cfg_t     cfg_i,
  output logic                cand_valid_o,
  output iatmr_pkg::cand_t    cand_o
);

  typedef struct packed {
    logic [iatmr_pkg::TIME_BITS-1:0] now_ms;
    logic                            link_up;
    logic [iatmr_pkg::TIME_BITS-1:0] base;
    logic [iatmr_pkg::SPAN_BITS-1:0] addend;
    logic                            sub;
  } part_t;

  typedef struct packed {
    logic [iatmr_pkg::TIME_BITS-1:0] now_ms;
    logic                            link_up;
    logic [iatmr_pkg::TIME_BITS-1:0] sched;
    logic                            sched_ok;
  } sched_t;

  iatmr_pkg::in_item_t in_q;
  part_t               part_q, part_d;
  sched_t              sched_q, sched_d;
  iatmr_pkg::cand_t    cand_q, cand_d;
  logic [3:0]          vld_q;
  logic                past_alarm;

  // first half: midnight or now plus span
  always_comb begin
    past_alarm     = cfg_i.span < iatmr_pkg::SPAN_BITS'(in_q.ms_of_day);
    part_d.now_ms  = in_q.now_ms;
    part_d.link_up = in_q.link_up;
    if (cfg_i.alarm_mode) begin
      part_d.base   = iatmr_pkg::sat_sub(in_q.now_ms,
                                         iatmr_pkg::TIME_BITS'(in_q.ms_of_day));
      part_d.addend = cfg_i.span + (past_alarm ? iatmr_pkg::MS_PER_DAY : '0);
      part_d.sub    = 1'b0;
    end else begin
      part_d.base   = iatmr_pkg::sat_add(in_q.now_ms, iatmr_pkg::TIME_BITS'(cfg_i.span));
      part_d.addend = cfg_i.offset;
      part_d.sub    = 1'b1;
    end
  end

  // second half: time of day added, or offset taken off
  always_comb begin
    sched_d.now_ms   = part_q.now_ms;
    sched_d.link_up  = part_q.link_up;
    sched_d.sched_ok = !cfg_i.alarm_mode || cfg_i.at_ok;
    if (part_q.sub) begin
      sched_d.sched = iatmr_pkg::sat_sub(part_q.base, iatmr_pkg::TIME_BITS'(part_q.addend));
    end else begin
      sched_d.sched = iatmr_pkg::sat_add(part_q.base, iatmr_pkg::TIME_BITS'(part_q.addend));
    end
    if (!sched_d.sched_ok) begin
      sched_d.sched = '0;
    end
  end

  // due check and the move after a fire
  always_comb begin
    cand_d.now_ms       = sched_q.now_ms;
    cand_d.link_up      = sched_q.link_up;
    cand_d.sched        = sched_q.sched;
    cand_d.sched_ok     = sched_q.sched_ok;
    cand_d.sched_le     = sched_q.sched <= sched_q.now_ms;
    cand_d.sched_adv    = iatmr_pkg::sat_add(sched_q.sched,
                                             iatmr_pkg::TIME_BITS'(cfg_i.step));
    cand_d.sched_adv_le = cand_d.sched_adv <= sched_q.now_ms;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      in_q    <= in_data_i;
      part_q  <= part_d;
      sched_q <= sched_d;
      cand_q  <= cand_d;
    end
  end

  assign cand_valid_o = vld_q[3];
  assign cand_o       = cand_q;

endmodule

/* hw/rtl/iatmr_core.sv */
// ----------------------------------------------------------------------------
// iatmr_core
// Schedule state, fire decision, fire counter and the result register.
// ----------------------------------------------------------------------------
module iatmr_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cand_valid_i,
  input  iatmr_pkg::cand_t     cand_i,
  input  iatmr_pkg::cfg_t      cfg_i,
  output logic                 adv_o,
  output logic                 shot_clear_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output iatmr_pkg::out_item_t out_data_o
);

  logic [iatmr_pkg::TIME_BITS-1:0]  next_q, next_d;
  logic                             nvalid_q, nvalid_d;
  logic [iatmr_pkg::TIME_BITS-1:0]  last_q, last_d;
  logic [iatmr_pkg::COUNT_BITS-1:0] count_q, count_d;
  iatmr_pkg::out_item_t             out_q, out_d;
  logic                             out_valid_q, out_valid_d;

  logic                             take, active, fire;
  logic [iatmr_pkg::TIME_BITS-1:0]  cur, cur_adv;
  logic                             cur_ok, cur_le, cur_adv_le;

  assign adv_o  = !out_valid_q || out_ready_i;
  assign take   = cand_valid_i && adv_o;
  assign active = cfg_i.enable && (cfg_i.run_disconnected || cand_i.link_up);

  always_comb begin
    if (nvalid_q) begin
      cur        = next_q;
      cur_ok     = 1'b1;
      cur_le     = next_q <= cand_i.now_ms;
      cur_adv    = iatmr_pkg::sat_add(next_q, iatmr_pkg::TIME_BITS'(cfg_i.step));
      cur_adv_le = cur_adv <= cand_i.now_ms;
    end else begin
      cur        = cand_i.sched;
      cur_ok     = cand_i.sched_ok;
      cur_le     = cand_i.sched_le;
      cur_adv    = cand_i.sched_adv;
      cur_adv_le = cand_i.sched_adv_le;
    end
    fire = take && active && cur_ok && cur_le;

    next_d   = next_q;
    nvalid_d = nvalid_q;
    last_d   = last_q;
    count_d  = count_q;
    if (take && active) begin
      next_d   = cur;
      nvalid_d = cur_ok;
      if (!nvalid_q || fire) begin
        last_d = cand_i.now_ms;
      end
      if (fire) begin
        count_d = count_q + iatmr_pkg::COUNT_BITS'(1);
        if (cur_adv_le) begin
          next_d   = cand_i.sched;
          nvalid_d = cand_i.sched_ok;
        end else begin
          next_d   = cur_adv;
          nvalid_d = 1'b1;
        end
      end
    end

    out_d.fired        = fire;
    out_d.next_fire_ms = nvalid_d ? next_d : '0;
    out_d.next_fire_ok = nvalid_d;
    out_d.fires_so_far = count_d;
    out_d.last_fire_ms = last_d;

    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign shot_clear_o = fire && cfg_i.single_shot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q      <= '0;
      nvalid_q    <= 1'b0;
      last_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      next_q      <= next_d;
      nvalid_q    <= nvalid_d;
      last_q      <= last_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_on_fire : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> count_q == $past(count_q) + iatmr_pkg::COUNT_BITS'(1))
    else $error("fire count did not step");

  a_state_holds_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(count_q) && $stable(nvalid_q) && $stable(next_q) && $stable(last_q))
    else $error("schedule state moved without an item");

  a_no_sched_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !nvalid_q |-> next_q == '0)
    else $error("stale time kept without a schedule");

  a_result_matches_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.fires_so_far == count_q) && (out_q.next_fire_ok == nvalid_q))
    else $error("pending result out of step with state");

endmodule

/* hw/rtl/interval_and_alarm_timer_top.sv */
// ----------------------------------------------------------------------------
// interval_and_alarm_timer_top
// Interval and time-of-day alarm timer. Each item is one time tick (absolute
// milliseconds, milliseconds since midnight, link state) and gives one result
// with the fire flag, the schedule, the fire count and the last fire time.
// One item is taken every clock while the result is not stalled; each item passes
// through the input register, three stages that build the fresh schedule and its
// due check, and the state update feeding the result register. The schedule state
// turns over once per clock in the last stage, which sets the rate of one item a
// cycle. A stalled result holds back the whole pipeline. Settings sit in their own
// write port; the user must change them only with no item in flight, as the block
// itself does not enforce this; after reset all settings are zero and there is no
// schedule.
// ----------------------------------------------------------------------------
module interval_and_alarm_timer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  iatmr_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output iatmr_pkg::out_item_t                out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [iatmr_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [iatmr_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  iatmr_pkg::cfg_t  cfg;
  iatmr_pkg::cand_t cand;
  logic             cand_valid;
  logic             adv;
  logic             shot_clear;

  iatmr_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .shot_clear_i (shot_clear),
    .cfg_o        (cfg)
  );

  iatmr_sched u_sched (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .adv_i        (adv),
    .cfg_i        (cfg),
    .cand_valid_o (cand_valid),
    .cand_o       (cand)
  );

  iatmr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cand_valid_i (cand_valid),
    .cand_i       (cand),
    .cfg_i        (cfg),
    .adv_o        (adv),
    .shot_clear_o (shot_clear),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  assign in_ready_o = adv;

endmodule

/* tb/sv/tb_interval_and_alarm_timer_top.sv */
// ----------------------------------------------------------------------------
// tb_interval_and_alarm_timer_top
// Self-checking bench for the interval and alarm timer. A scripted opening
// covers blocked ticks, zero and wide intervals, saturation at the top of the
// time range, bad alarm times, the offset, one-shot and midnight handling;
// random segments then reprogram the settings between runs of ticks with a
// moving clock. Every result is compared against a behavioural copy of the
// timer state or a result given in the script, with random gaps and stalls
// on both sides and one long output stall that backs the pipeline up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_interval_and_alarm_timer_top;

  localparam int          RANDOM_TICKS = 420;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [63:0] TIME_TOP     = (64'd1 << iatmr_pkg::TIME_BITS) - 64'd1;
  localparam logic [63:0] DAY_MS       = 64'(iatmr_pkg::MS_PER_DAY);
  localparam logic [iatmr_pkg::TIME_BITS-1:0] T_MAX = {iatmr_pkg::TIME_BITS{1'b1}};

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    iatmr_pkg::cfg_reg_e  sel;
    logic [31:0]          value;
    iatmr_pkg::in_item_t  tick;
    bit                   typed;
    iatmr_pkg::out_item_t want;
  } script_row_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_ready_o;
  iatmr_pkg::in_item_t                 in_data_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  iatmr_pkg::out_item_t                out_data_o;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [iatmr_pkg::CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [iatmr_pkg::CFG_DATA_BITS-1:0] cfg_data_i;

  // timer settings and state as tracked by the bench
  logic                             s_enable = 1'b0;
  logic                             s_alarm = 1'b0;
  logic [iatmr_pkg::HOUR_BITS-1:0]  s_hours = '0;
  logic [iatmr_pkg::MIN_BITS-1:0]   s_minutes = '0;
  logic [iatmr_pkg::SEC_BITS-1:0]   s_sec_ms = '0;
  logic [iatmr_pkg::SPAN_BITS-1:0]  s_offset = '0;
  logic                             s_run_disc = 1'b0;
  logic                             s_single = 1'b0;
  logic [iatmr_pkg::TIME_BITS-1:0]  sched_at = '0;
  logic                             sched_ok = 1'b0;
  logic [iatmr_pkg::TIME_BITS-1:0]  last_fire_at = '0;
  logic [iatmr_pkg::COUNT_BITS-1:0] fire_tally = '0;
  logic                             oneshot_spent = 1'b0;

  iatmr_pkg::out_item_t pending[$];
  script_row_t          plan[$];

  int send_gap_pct = 21;
  int recv_stall_pct = 75;
  int hold_cycles = 0;
  int ticks_sent = 0;
  int fires_seen = 0;
  int writes_done = 0;
  int results_checked = 0;
  int mismatches = 0;
  int orphans = 0;
  int cycles = 0;

  interval_and_alarm_timer_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] field_mask(iatmr_pkg::cfg_reg_e r);
    case (r)
      iatmr_pkg::REG_HOURS, iatmr_pkg::REG_MINUTES: return 32'h0000_00FF;
      iatmr_pkg::REG_SECOND_MILLIS:                 return 32'h0000_FFFF;
      iatmr_pkg::REG_OFFSET_MILLIS:                 return 32'h3FFF_FFFF;
      default:                                      return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [iatmr_pkg::TIME_BITS-1:0] clamp_add(
      logic [iatmr_pkg::TIME_BITS-1:0] a, logic [63:0] b);
    logic [63:0] s;
    s = 64'(a) + b;
    return (s > TIME_TOP) ? T_MAX : s[iatmr_pkg::TIME_BITS-1:0];
  endfunction

  function automatic logic [iatmr_pkg::TIME_BITS-1:0] floor_sub(
      logic [iatmr_pkg::TIME_BITS-1:0] a, logic [63:0] b);
    return (b > 64'(a)) ? '0 : a - b[iatmr_pkg::TIME_BITS-1:0];
  endfunction

  function automatic logic [63:0] interval_len();
    return 64'(s_hours) * 64'(iatmr_pkg::MS_PER_HOUR)
           + 64'(s_minutes) * 64'(iatmr_pkg::MS_PER_MINUTE) + 64'(s_sec_ms);
  endfunction

  function automatic void take_setting(iatmr_pkg::cfg_reg_e r, logic [31:0] v);
    case (r)
      iatmr_pkg::REG_ENABLE: begin
        s_enable = v[0];
        oneshot_spent = 1'b0;
      end
      iatmr_pkg::REG_ALARM_MODE:    s_alarm = v[0];
      iatmr_pkg::REG_HOURS:         s_hours = v[iatmr_pkg::HOUR_BITS-1:0];
      iatmr_pkg::REG_MINUTES:       s_minutes = v[iatmr_pkg::MIN_BITS-1:0];
      iatmr_pkg::REG_SECOND_MILLIS: s_sec_ms = v[iatmr_pkg::SEC_BITS-1:0];
      iatmr_pkg::REG_OFFSET_MILLIS: s_offset = v[iatmr_pkg::SPAN_BITS-1:0];
      iatmr_pkg::REG_RUN_DISC:      s_run_disc = v[0];
      iatmr_pkg::REG_SINGLE_SHOT:   s_single = v[0];
      default: ;
    endcase
  endfunction

  function automatic void build_schedule(logic [iatmr_pkg::TIME_BITS-1:0] tnow,
                                         logic [iatmr_pkg::TOD_BITS-1:0] tod);
    logic [63:0]                     at;
    logic [iatmr_pkg::TIME_BITS-1:0] when;
    last_fire_at = tnow;
    if (s_alarm) begin
      if (s_hours >= iatmr_pkg::HOURS_PER_DAY || s_minutes >= iatmr_pkg::MINS_PER_HOUR
          || s_sec_ms >= iatmr_pkg::MS_PER_MIN_SEC) begin
        sched_ok = 1'b0;
        sched_at = '0;
      end else begin
        at = interval_len();
        when = clamp_add(floor_sub(tnow, 64'(tod)), at);
        if (at < 64'(tod)) when = clamp_add(when, DAY_MS);
        sched_at = when;
        sched_ok = 1'b1;
      end
    end else begin
      sched_at = floor_sub(clamp_add(tnow, interval_len()), 64'(s_offset));
      sched_ok = 1'b1;
    end
  endfunction

  function automatic iatmr_pkg::out_item_t timer_after_tick(iatmr_pkg::in_item_t t);
    iatmr_pkg::out_item_t            r;
    logic [iatmr_pkg::TIME_BITS-1:0] tnow;
    r = '0;
    tnow = t.now_ms;
    if (s_enable && (s_run_disc || t.link_up)) begin
      if (!sched_ok) build_schedule(tnow, t.ms_of_day);
      if (sched_ok && sched_at <= tnow) begin
        r.fired = 1'b1;
        fire_tally = fire_tally + 1'b1;
        last_fire_at = tnow;
        sched_at = clamp_add(sched_at, s_alarm ? DAY_MS : interval_len());
        if (sched_at <= tnow) build_schedule(tnow, t.ms_of_day);
        if (s_single) begin
          s_enable = 1'b0;
          oneshot_spent = 1'b1;
        end
      end
    end
    r.next_fire_ms = sched_ok ? sched_at : '0;
    r.next_fire_ok = sched_ok;
    r.fires_so_far = fire_tally;
    r.last_fire_ms = last_fire_at;
    return r;
  endfunction

  function automatic void plan_write(iatmr_pkg::cfg_reg_e sel, logic [31:0] value);
    script_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.sel = sel;
    row.value = value;
    plan.push_back(row);
  endfunction

  function automatic void plan_tick(logic [iatmr_pkg::TIME_BITS-1:0] tnow,
                                    logic [iatmr_pkg::TOD_BITS-1:0] tod,
                                    logic link, bit typed, iatmr_pkg::out_item_t want);
    script_row_t row;
    row = '0;
    row.kind = ROW_TICK;
    row.tick.now_ms = tnow;
    row.tick.ms_of_day = tod;
    row.tick.link_up = link;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endfunction

  task automatic send_tick(iatmr_pkg::in_item_t t, bit typed, iatmr_pkg::out_item_t want);
    iatmr_pkg::out_item_t guess;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    guess = timer_after_tick(t);
    pending.push_back(typed ? want : guess);
    ticks_sent++;
    if (guess.fired) fires_seen++;
  endtask

  // settings change only with nothing in flight
  task automatic write_setting(iatmr_pkg::cfg_reg_e r, logic [31:0] v);
    logic [31:0] data;
    data = v;
    if ($urandom_range(7) == 0) data = data | ($urandom & ~field_mask(r));
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    take_setting(r, data);
    cfg_valid_i <= 1'b0;
    writes_done++;
  endtask

  task automatic randomise_settings();
    logic                            alarm;
    logic [iatmr_pkg::HOUR_BITS-1:0] hh;
    logic [iatmr_pkg::MIN_BITS-1:0]  mm;
    logic [iatmr_pkg::SEC_BITS-1:0]  ss;
    logic [31:0]                     off;
    logic [63:0]                     span;
    int                              r;
    alarm = ($urandom_range(9) < 3);
    if (alarm && $urandom_range(9) != 0) begin
      hh = iatmr_pkg::HOUR_BITS'($urandom_range(23));
      mm = iatmr_pkg::MIN_BITS'($urandom_range(59));
      ss = iatmr_pkg::SEC_BITS'($urandom_range(59999));
    end else if (alarm) begin
      hh = iatmr_pkg::HOUR_BITS'($urandom);
      mm = iatmr_pkg::MIN_BITS'($urandom);
      ss = iatmr_pkg::SEC_BITS'($urandom);
    end else begin
      hh = ($urandom_range(15) == 0) ? iatmr_pkg::HOUR_BITS'($urandom) : '0;
      mm = iatmr_pkg::MIN_BITS'($urandom_range(2));
      ss = iatmr_pkg::SEC_BITS'($urandom);
    end
    span = 64'(hh) * 64'(iatmr_pkg::MS_PER_HOUR) + 64'(mm) * 64'(iatmr_pkg::MS_PER_MINUTE)
           + 64'(ss);
    r = $urandom_range(7);
    off = (r < 4) ? 32'd0 : (r < 7) ? $urandom_range(32'(span)) : ($urandom & 32'h3FFF_FFFF);
    if ($urandom_range(3) != 0) write_setting(iatmr_pkg::REG_ALARM_MODE, 32'(alarm));
    if ($urandom_range(3) != 0) write_setting(iatmr_pkg::REG_HOURS, 32'(hh));
    if ($urandom_range(3) != 0) write_setting(iatmr_pkg::REG_MINUTES, 32'(mm));
    if ($urandom_range(3) != 0) write_setting(iatmr_pkg::REG_SECOND_MILLIS, 32'(ss));
    if ($urandom_range(3) != 0) write_setting(iatmr_pkg::REG_OFFSET_MILLIS, off);
    if ($urandom_range(3) != 0)
      write_setting(iatmr_pkg::REG_RUN_DISC, 32'($urandom_range(1)));
    if ($urandom_range(3) != 0)
      write_setting(iatmr_pkg::REG_SINGLE_SHOT, 32'($urandom_range(4) == 0));
    write_setting(iatmr_pkg::REG_ENABLE, 32'($urandom_range(9) != 0));
  endtask

  // a clock that mostly moves forward, with jumps, steps back and odd day times
  task automatic run_segment(int n);
    logic [63:0]         tnow;
    logic [63:0]         mid;
    logic [63:0]         stride;
    logic [63:0]         hop;
    iatmr_pkg::in_item_t t;
    int                  r;
    stride = s_alarm ? DAY_MS / 3 : (interval_len() == 0 ? 64'd1000 : interval_len());
    r = $urandom_range(7);
    if (r == 0) tnow = TIME_TOP - 64'($urandom_range(200_000_000));
    else if (r == 1) tnow = 64'($urandom_range(100000));
    else tnow = ({$urandom, $urandom} >> $urandom_range(12)) & TIME_TOP;
    hop = 64'($urandom_range(32'(DAY_MS) - 1));
    mid = (tnow > hop) ? tnow - hop : 64'd0;
    repeat (n) begin
      r = $urandom_range(31);
      if (r == 0) begin
        hop = 64'($urandom_range(32'(stride)));
        tnow = (hop > tnow) ? 64'd0 : tnow - hop;
      end else if (r <= 2) begin
        tnow = tnow + stride * 64'($urandom_range(10) + 2);
      end else begin
        tnow = tnow + 64'($urandom_range(32'(stride)));
      end
      if (tnow > TIME_TOP) tnow = TIME_TOP;
      t.now_ms = tnow[iatmr_pkg::TIME_BITS-1:0];
      if (r == 3) t.ms_of_day = iatmr_pkg::TOD_BITS'($urandom);
      else t.ms_of_day = (tnow >= mid) ? iatmr_pkg::TOD_BITS'((tnow - mid) % DAY_MS) : '0;
      t.link_up = ($urandom_range(9) != 0);
      send_tick(t, 1'b0, '0);
    end
  endtask

  // result side: check, then choose ready for the next cycle
  initial begin
    iatmr_pkg::out_item_t want;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending.size() == 0) begin
          orphans++;
          $display("result with nothing expected: %h", out_data_o);
        end else begin
          want = pending.pop_front();
          results_checked++;
          if (out_data_o.fired !== want.fired || out_data_o.next_fire_ms !== want.next_fire_ms
              || out_data_o.next_fire_ok !== want.next_fire_ok
              || out_data_o.fires_so_far !== want.fires_so_far
              || out_data_o.last_fire_ms !== want.last_fire_ms) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch on result %0d: exp fired %0d next %h ok %0d count %h last %h",
                       results_checked, want.fired, want.next_fire_ms, want.next_fire_ok,
                       want.fires_so_far, want.last_fire_ms);
              $display("  got fired %0d next %h ok %0d count %h last %h",
                       out_data_o.fired, out_data_o.next_fire_ms, out_data_o.next_fire_ok,
                       out_data_o.fires_so_far, out_data_o.last_fire_ms);
            end
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int  directed;
    int  phase;
    bit  squeezed;
    squeezed = 1'b0;
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= iatmr_pkg::REG_ENABLE;
    cfg_data_i <= '0;

    // blocked ticks, zero interval, then wide interval with junk in the upper bits
    plan_tick(48'd1000, 27'd1000, 1'b1, 1'b1, '0);
    plan_write(iatmr_pkg::REG_ENABLE, 32'd1);
    plan_tick(48'd5000, 27'd5000, 1'b0, 1'b1, '0);
    plan_tick(48'd5000, 27'd5000, 1'b1, 1'b1,
              iatmr_pkg::out_item_t'{1'b1, 48'd5000, 1'b1, 32'd1, 48'd5000});
    plan_write(iatmr_pkg::REG_MINUTES, 32'd1);
    plan_write(iatmr_pkg::REG_SECOND_MILLIS, 32'hFFFF_FFFF);
    plan_tick(48'd6000, 27'd6000, 1'b1, 1'b0, '0);
    plan_tick(48'd130534, 27'd130534, 1'b1, 1'b0, '0);
    plan_tick(48'd130535, 27'd130535, 1'b1, 1'b0, '0);
    plan_tick(48'd0, 27'd0, 1'b1, 1'b0, '0);
    // top of the time range, saturating schedule
    plan_tick(T_MAX, '1, 1'b1, 1'b0, '0);
    plan_tick(T_MAX, '1, 1'b1, 1'b0, '0);
    // bad alarm time drops the schedule
    plan_write(iatmr_pkg::REG_ALARM_MODE, 32'd1);
    plan_write(iatmr_pkg::REG_HOURS, 32'd255);
    plan_tick(T_MAX, 27'd0, 1'b1, 1'b0, '0);
    plan_tick(48'd2000, 27'd2000, 1'b1, 1'b0, '0);
    // offset larger than the interval
    plan_write(iatmr_pkg::REG_ALARM_MODE, 32'd0);
    plan_write(iatmr_pkg::REG_OFFSET_MILLIS, 32'hFFFF_FFFF);
    plan_tick(48'd1000, 27'd1000, 1'b1, 1'b0, '0);
    plan_write(iatmr_pkg::REG_ENABLE, 32'd0);
    plan_tick(48'd2_000_000_000, 27'd0, 1'b1, 1'b0, '0);
    // one-shot alarm at the last millisecond of the day, link down
    plan_write(iatmr_pkg::REG_RUN_DISC, 32'd1);
    plan_write(iatmr_pkg::REG_SINGLE_SHOT, 32'd1);
    plan_write(iatmr_pkg::REG_ENABLE, 32'd1);
    plan_write(iatmr_pkg::REG_ALARM_MODE, 32'd1);
    plan_write(iatmr_pkg::REG_HOURS, 32'd23);
    plan_write(iatmr_pkg::REG_MINUTES, 32'd59);
    plan_write(iatmr_pkg::REG_SECOND_MILLIS, 32'd59999);
    plan_tick(48'd2_000_000_000, 27'd0, 1'b0, 1'b0, '0);
    plan_tick(48'd3_000_000_000, 27'd0, 1'b1, 1'b0, '0);
    // alarm already passed today moves to tomorrow
    plan_write(iatmr_pkg::REG_ENABLE, 32'd1);
    plan_write(iatmr_pkg::REG_HOURS, 32'd0);
    plan_write(iatmr_pkg::REG_MINUTES, 32'd0);
    plan_write(iatmr_pkg::REG_SECOND_MILLIS, 32'd0);
    plan_tick(48'd5_000_000_000, 27'd5000, 1'b1, 1'b0, '0);
    plan_write(iatmr_pkg::REG_SINGLE_SHOT, 32'd0);
    plan_write(iatmr_pkg::REG_MINUTES, 32'd60);
    plan_write(iatmr_pkg::REG_ENABLE, 32'd1);
    plan_tick(48'd6_000_000_000, 27'd0, 1'b1, 1'b0, '0);
    // day time beyond now, midnight clamps at zero
    plan_write(iatmr_pkg::REG_MINUTES, 32'd0);
    plan_tick(48'd100, '1, 1'b1, 1'b0, '0);
    plan_tick(48'd86_400_000, 27'd0, 1'b1, 1'b0, '0);
    plan_write(iatmr_pkg::REG_RUN_DISC, 32'd0);
    plan_tick(48'd172_800_000, 27'd0, 1'b0, 1'b0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_setting(plan[i].sel, plan[i].value);
      else send_tick(plan[i].tick, plan[i].typed, plan[i].want);
    end
    directed = ticks_sent;

    while (ticks_sent - directed < RANDOM_TICKS) begin
      phase = (ticks_sent - directed) / (RANDOM_TICKS / 3);
      case (phase)
        0: begin
          send_gap_pct = 21;
          recv_stall_pct = 75;
        end
        1: begin
          send_gap_pct = 75;
          recv_stall_pct = 21;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      randomise_settings();
      if (phase >= 2 && !squeezed) begin
        hold_cycles = 300;
        squeezed = 1'b1;
      end
      run_segment($urandom_range(30, 10));
    end

    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("covered %0d ticks (%0d scripted), %0d fires, %0d setting writes",
             ticks_sent, directed, fires_seen, writes_done);
    $display("%0d results checked, %0d mismatched, %0d unexpected, %0d missing",
             results_checked, mismatches, orphans, pending.size());
    if (mismatches == 0 && orphans == 0 && pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
